[src/char_lcd_stream_sequencer_unit_defines.svh]
// ----------------------------------------------------------------------------
// Character LCD stream sequencer: assertion macros
// Shorthand for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_STREAM_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_STREAM_SEQUENCER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLSS_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLSS_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/clss_pkg.sv]
// ----------------------------------------------------------------------------
// clss_pkg
// Shared types and constants of the character LCD stream sequencer.
// ----------------------------------------------------------------------------
package clss_pkg;

	localparam int COLUMNS = 16;

	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_HOME    = 8'h02;
	localparam logic [7:0] CMD_LINE0   = 8'h80;
	localparam logic [7:0] CMD_LINE1   = 8'hC0;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;

	// Display set-up commands and the nibbles that wake the controller.
	localparam logic [7:0] CMD_FUNC_4BIT   = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
	localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
	localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
	localparam logic [7:0] WAKE_NIBBLE     = 8'h30;
	localparam logic [7:0] FOUR_BIT_NIBBLE = 8'h20;

	typedef enum logic [2:0] {
		MODE_CHAR  = 3'd0,
		MODE_CLEAR = 3'd1,
		MODE_HOME  = 3'd2,
		MODE_SETPOS = 3'd3,
		MODE_INIT  = 3'd4
	} mode_t;

	// Transfers that come before the main one when the cursor wraps.
	typedef enum logic [1:0] {
		PRE_NONE      = 2'd0,
		PRE_LINE1     = 2'd1,
		PRE_CLEAR_TOP = 2'd2
	} pre_t;

	// One queued item of work for the byte sequencer.
	typedef struct packed {
		logic       init;
		pre_t       pre;
		logic       has_main;
		logic [7:0] value;
		logic       rs;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} back_status_t;

endpackage

[src/clss_cmd_if.sv]
// ----------------------------------------------------------------------------
// clss_cmd_if
// Command channel: characters and display commands with valid/ready.
// ----------------------------------------------------------------------------
interface clss_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] char_code;
	logic       target_line;
	logic [7:0] target_column;

	modport source(output valid, mode, char_code, target_line, target_column, input ready);
	modport sink(input valid, mode, char_code, target_line, target_column, output ready);
endinterface

[src/clss_byte_if.sv]
// ----------------------------------------------------------------------------
// clss_byte_if
// Byte channel: expander bytes with their trailing wait, valid/ready.
// ----------------------------------------------------------------------------
interface clss_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  expander_byte;
	logic [12:0] wait_after_us;
	logic        last;

	modport source(output valid, expander_byte, wait_after_us, last, input ready);
	modport sink(input valid, expander_byte, wait_after_us, last, output ready);
endinterface

[src/clss_front.sv]
// ----------------------------------------------------------------------------
// clss_front
// Accepts command items, tracks the cursor and turns each item into a job.
// ----------------------------------------------------------------------------
module clss_front (
	input  logic          clk,
	input  logic          arst_n,
	clss_cmd_if.sink      cmd,
	input  logic          q_full,
	output logic          push,
	output clss_pkg::job_t job
);
	import clss_pkg::*;

	logic       line_q;
	logic [5:0] col_q;
	logic       accept;
	logic       wrapping;
	logic       line_d;
	logic [5:0] col_d;
	logic       known;
	logic [5:0] set_col;

	assign cmd.ready = !q_full;
	assign accept    = cmd.valid && cmd.ready;
	assign set_col   = 6'(cmd.target_column % COLUMNS);
	assign wrapping  = (cmd.char_code == CHAR_NEWLINE) || (col_q >= 6'(COLUMNS));

	always_comb begin
		job      = '0;
		job.pre  = PRE_NONE;
		line_d   = line_q;
		col_d    = col_q;
		known    = 1'b1;
		case (cmd.mode)
			MODE_CHAR: begin
				if (wrapping) begin
					job.pre = line_q ? PRE_CLEAR_TOP : PRE_LINE1;
					line_d  = ~line_q;
				end
				if (cmd.char_code == CHAR_NEWLINE) begin
					col_d = '0;
				end else begin
					job.has_main = 1'b1;
					job.value    = cmd.char_code;
					job.rs       = 1'b1;
					col_d        = wrapping ? 6'd1 : col_q + 6'd1;
				end
			end
			MODE_CLEAR: begin
				job.has_main = 1'b1;
				job.value    = CMD_CLEAR;
				line_d       = 1'b0;
				col_d        = '0;
			end
			MODE_HOME: begin
				job.has_main = 1'b1;
				job.value    = CMD_HOME;
				line_d       = 1'b0;
				col_d        = '0;
			end
			MODE_SETPOS: begin
				job.has_main = 1'b1;
				job.value    = (cmd.target_line ? CMD_LINE1 : CMD_LINE0) + {2'b00, set_col};
				line_d       = cmd.target_line;
				col_d        = set_col;
			end
			MODE_INIT: begin
				job.init = 1'b1;
				line_d   = 1'b0;
				col_d    = '0;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// Unused modes are taken and dropped without touching the cursor.
	assign push = accept && known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= 1'b0;
			col_q  <= '0;
		end else if (push) begin
			line_q <= line_d;
			col_q  <= col_d;
		end
	end
endmodule

[src/clss_fifo.sv]
// ----------------------------------------------------------------------------
// clss_fifo
// Two-entry job queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module clss_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  clss_pkg::job_t        wr_job,
	input  logic                  pop,
	output clss_pkg::job_t        rd_job,
	output clss_pkg::fifo_status_t status
);
	import clss_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rd_job       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

[src/clss_back.sv]
// ----------------------------------------------------------------------------
// clss_back
// Expands queued jobs into expander bytes, one byte per cycle while lcd.ready is high.
// ----------------------------------------------------------------------------
module clss_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  clss_pkg::job_t         job,
	input  logic                   q_empty,
	output clss_pkg::back_status_t status,
	clss_byte_if.source            lcd
);
	import clss_pkg::*;

	typedef struct packed {
		logic [7:0]  value;
		logic        rs;
		logic        nib_only;
		logic [12:0] tail;
		logic        final_xfer;
	} xfer_t;

	localparam logic [12:0] WAIT_ENABLE   = 13'd1;
	localparam logic [12:0] WAIT_NIBBLE   = 13'd50;
	localparam logic [12:0] WAIT_CMD      = 13'd100;
	localparam logic [12:0] WAIT_SLOW_CMD = 13'd2050;
	localparam logic [12:0] WAIT_POWERUP  = 13'd5050;
	localparam logic [12:0] WAIT_INIT     = 13'd200;

	function automatic logic [12:0] cmd_tail(input logic [7:0] v, input logic rs);
		cmd_tail = (!rs && (v inside {CMD_CLEAR, CMD_HOME})) ? WAIT_SLOW_CMD : WAIT_CMD;
	endfunction

	// Describes transfer number idx of a job.
	function automatic xfer_t xfer_desc(input job_t j, input logic [3:0] idx);
		xfer_t      d;
		logic [1:0] npre;
		d    = '0;
		npre = (j.pre == PRE_NONE) ? 2'd0 : ((j.pre == PRE_LINE1) ? 2'd1 : 2'd2);
		if (j.init) begin
			case (idx)
				4'd0: begin d.value = WAKE_NIBBLE; d.nib_only = 1'b1; d.tail = WAIT_POWERUP; end
				4'd1: begin d.value = WAKE_NIBBLE; d.nib_only = 1'b1; d.tail = WAIT_INIT; end
				4'd2: begin d.value = WAKE_NIBBLE; d.nib_only = 1'b1; d.tail = WAIT_INIT; end
				4'd3: begin d.value = FOUR_BIT_NIBBLE; d.nib_only = 1'b1; d.tail = WAIT_INIT; end
				4'd4: d.value = CMD_FUNC_4BIT;
				4'd5: d.value = CMD_DISPLAY_OFF;
				4'd6: d.value = CMD_CLEAR;
				4'd7: d.value = CMD_ENTRY_MODE;
				default: begin d.value = CMD_DISPLAY_ON; d.final_xfer = 1'b1; end
			endcase
			if (!d.nib_only) begin
				d.tail = cmd_tail(d.value, 1'b0);
			end
		end else if (idx < {2'b00, npre}) begin
			if (j.pre == PRE_LINE1) begin
				d.value = CMD_LINE1;
			end else begin
				d.value = (idx == 4'd0) ? CMD_CLEAR : CMD_LINE0;
			end
			d.tail       = cmd_tail(d.value, 1'b0);
			d.final_xfer = (idx == {2'b00, npre} - 4'd1) && !j.has_main;
		end else begin
			d.value      = j.value;
			d.rs         = j.rs;
			d.tail       = cmd_tail(j.value, j.rs);
			d.final_xfer = 1'b1;
		end
		return d;
	endfunction

	job_t        job_q;
	logic        busy_q;
	logic [3:0]  xidx_q;
	logic        half_q;
	logic [1:0]  phase_q;
	logic        ov_q;
	logic [7:0]  obyte_q;
	logic [12:0] owait_q;
	logic        olast_q;

	xfer_t       d;
	logic [3:0]  nib;
	logic        final_nib;
	logic        last_byte;
	logic        emit;
	logic        pop;
	logic [7:0]  byte_d;
	logic [12:0] wait_d;

	always_comb begin
		d         = xfer_desc(job_q, xidx_q);
		nib       = half_q ? d.value[3:0] : d.value[7:4];
		final_nib = d.nib_only || half_q;
		last_byte = (phase_q == 2'd2) && final_nib && d.final_xfer;
		// Backlight always on, read/write always low.
		byte_d    = {nib, 1'b1, (phase_q == 2'd1), 1'b0, d.rs};
		case (phase_q)
			2'd0:    wait_d = '0;
			2'd1:    wait_d = WAIT_ENABLE;
			default: wait_d = final_nib ? d.tail : WAIT_NIBBLE;
		endcase
	end

	assign emit = busy_q && (!ov_q || lcd.ready);
	assign pop  = !q_empty && (!busy_q || (emit && last_byte));

	assign status.pop  = pop;
	assign status.busy = busy_q;

	assign lcd.valid         = ov_q;
	assign lcd.expander_byte = obyte_q;
	assign lcd.wait_after_us = owait_q;
	assign lcd.last          = olast_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (emit) begin
			obyte_q <= byte_d;
			owait_q <= wait_d;
			olast_q <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			xidx_q  <= '0;
			half_q  <= 1'b0;
			phase_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (lcd.ready) begin
				ov_q <= 1'b0;
			end

			if (pop) begin
				busy_q  <= 1'b1;
				xidx_q  <= '0;
				half_q  <= 1'b0;
				phase_q <= '0;
			end else if (emit) begin
				if (phase_q != 2'd2) begin
					phase_q <= phase_q + 2'd1;
				end else begin
					phase_q <= '0;
					if (!final_nib) begin
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						if (d.final_xfer) begin
							busy_q <= 1'b0;
						end else begin
							xidx_q <= xidx_q + 4'd1;
						end
					end
				end
			end
		end
	end
endmodule

[src/char_lcd_stream_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// char_lcd_stream_sequencer_unit
// Turns characters and display commands into expander bytes for a 4-bit LCD.
// ----------------------------------------------------------------------------
// Usage:
// The cmd channel takes one item per cycle while the job queue has room: a
// character, clear, home, set position or initialize. Modes 5 to 7 are taken
// and dropped. The lcd channel gives the expander bytes, each with the wait
// in microseconds that must follow it on the link; last marks the final byte
// of an item. A character gives 6 bytes, 12 when it wraps to line two and 18
// when it clears the screen, a newline 6 fewer; a command gives 6 and
// initialize gives 42. The first byte of an item passes through the job
// queue, the job register and the byte register before it appears. The
// byte sequencer sends one byte per cycle while lcd.ready is high; the
// two-entry job queue lets the front keep taking items meanwhile. When the
// receiver stalls, the byte register holds, the queue fills and cmd.ready
// drops. Reset puts the cursor at the top left and empties queue and output.
// ----------------------------------------------------------------------------
`include "char_lcd_stream_sequencer_unit_defines.svh"

module char_lcd_stream_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	clss_cmd_if.sink    cmd,
	clss_byte_if.source lcd
);
	import clss_pkg::*;

	job_t         push_job;
	job_t         head_job;
	logic         push;
	fifo_status_t fifo_st;
	back_status_t back_st;

	clss_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.q_full (fifo_st.full),
		.push   (push),
		.job    (push_job)
	);

	clss_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (back_st.pop),
		.rd_job (head_job),
		.status (fifo_st)
	);

	clss_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (head_job),
		.q_empty (fifo_st.empty),
		.status  (back_st),
		.lcd     (lcd)
	);

	`CLSS_ASSERT_NOW(a_full_stalls, clk, arst_n, fifo_st.full, !cmd.ready,
		"cmd taken with queue full")
	`CLSS_ASSERT_NEXT(a_pop_busy, clk, arst_n, back_st.pop, back_st.busy,
		"popped job not started")
	`CLSS_ASSERT_NOW(a_last_wait, clk, arst_n, lcd.valid && lcd.last,
		lcd.wait_after_us >= 13'd100, "short wait on final byte")
endmodule

[verif/tb_char_lcd_stream_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// tb_char_lcd_stream_sequencer_unit
// Sends characters, cursor moves and display commands into the sequencer and
// compares every expander byte, with its wait and last flag, against an
// in-bench model of the 4-bit LCD byte stream and the two-line cursor.
// ----------------------------------------------------------------------------
module tb_char_lcd_stream_sequencer_unit;
	import clss_pkg::*;

	localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] MODE_MID_UNUSED   = 3'd6;
	localparam logic [2:0] MODE_LAST_UNUSED  = 3'd7;

	localparam logic [7:0] BACKLIGHT   = 8'h08;
	localparam logic [7:0] ENABLE      = 8'h04;
	localparam logic [7:0] REGSEL      = 8'h01;
	localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

	localparam logic [12:0] WAIT_DATA      = 13'd0;
	localparam logic [12:0] WAIT_EN_HIGH   = 13'd1;
	localparam logic [12:0] WAIT_EN_LOW    = 13'd50;
	localparam logic [12:0] WAIT_CMD       = 13'd50;
	localparam logic [12:0] WAIT_SLOW_CMD  = 13'd2000;
	localparam logic [12:0] WAIT_POWER_UP  = 13'd5000;
	localparam logic [12:0] WAIT_WAKE      = 13'd150;

	localparam int RANDOM_PER_PHASE = 130;
	localparam int STALL_LIMIT      = 4000;
	localparam int DRAIN_CYCLES     = 16;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] char_code;
		logic       target_line;
		logic [7:0] target_column;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0]  expander_byte;
		logic [12:0] wait_after_us;
		logic        last;
	} lcd_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	clss_cmd_if  cmd();
	clss_byte_if lcd();

	char_lcd_stream_sequencer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.lcd    (lcd)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cmd_item_t cmd_backlog[$];
	lcd_byte_t lcd_bytes_due[$];

	int send_idle_pct;
	int recv_idle_pct;

	// Cursor as the display sees it.
	logic       cur_line;
	logic [5:0] cur_col;

	int error_count;
	int items_taken;
	int bytes_checked;
	int init_count;
	int line_two_wraps;
	int clear_wraps;
	int stall_cycles;

	task automatic note_error(string what, int expected_val, int actual_val);
		error_count++;
		$display("%0t: %s expected %0d (0x%0h) got %0d (0x%0h)", $time, what,
			expected_val, expected_val, actual_val, actual_val);
	endtask

	function automatic void push_byte(logic [7:0] b, logic [12:0] w);
		lcd_bytes_due.push_back('{b, w, 1'b0});
	endfunction

	function automatic void push_nibble(logic [7:0] v, logic [12:0] tail);
		push_byte(v, WAIT_DATA);
		push_byte(v | ENABLE, WAIT_EN_HIGH);
		push_byte(v & ~ENABLE, WAIT_EN_LOW + tail);
	endfunction

	function automatic void push_transfer(logic [7:0] value, logic rs, logic [12:0] tail);
		logic [7:0] flags;
		flags = BACKLIGHT | (rs ? REGSEL : 8'h00);
		push_nibble((value & HIGH_NIBBLE) | flags, WAIT_DATA);
		push_nibble({value[3:0], 4'h0} | flags, tail);
	endfunction

	function automatic void push_command(logic [7:0] c);
		push_transfer(c, 1'b0, (c == CMD_CLEAR || c == CMD_HOME) ? WAIT_SLOW_CMD : WAIT_CMD);
	endfunction

	function automatic void move_cursor(logic line, logic [5:0] col);
		push_command((line ? CMD_LINE1 : CMD_LINE0) + {2'b00, col});
		cur_line = line;
		cur_col  = col;
	endfunction

	// Top line overflow moves to line two; bottom line overflow clears the screen and restarts at the top left.
	function automatic void wrap_cursor();
		if (cur_line == 1'b0) begin
			move_cursor(1'b1, 6'd0);
			line_two_wraps++;
		end else begin
			push_command(CMD_CLEAR);
			move_cursor(1'b0, 6'd0);
			clear_wraps++;
		end
	endfunction

	function automatic void predict_lcd_bytes(cmd_item_t it);
		int start_depth;
		lcd_byte_t tail_byte;
		start_depth = lcd_bytes_due.size();
		case (it.mode)
			MODE_CHAR: begin
				if (it.char_code == CHAR_NEWLINE) begin
					wrap_cursor();
				end else begin
					if (cur_col >= COLUMNS)
						wrap_cursor();
					push_transfer(it.char_code, 1'b1, WAIT_CMD);
					cur_col = cur_col + 6'd1;
				end
			end
			MODE_CLEAR, MODE_HOME: begin
				push_command(it.mode == MODE_CLEAR ? CMD_CLEAR : CMD_HOME);
				cur_line = 1'b0;
				cur_col  = 6'd0;
			end
			MODE_SETPOS: begin
				move_cursor(it.target_line, 6'(it.target_column % COLUMNS));
			end
			MODE_INIT: begin
				push_nibble(WAKE_NIBBLE | BACKLIGHT, WAIT_POWER_UP);
				push_nibble(WAKE_NIBBLE | BACKLIGHT, WAIT_WAKE);
				push_nibble(WAKE_NIBBLE | BACKLIGHT, WAIT_WAKE);
				push_nibble(FOUR_BIT_NIBBLE | BACKLIGHT, WAIT_WAKE);
				push_command(CMD_FUNC_4BIT);
				push_command(CMD_DISPLAY_OFF);
				push_command(CMD_CLEAR);
				push_command(CMD_ENTRY_MODE);
				push_command(CMD_DISPLAY_ON);
				cur_line = 1'b0;
				cur_col  = 6'd0;
				init_count++;
			end
			default: begin
			end
		endcase
		if (lcd_bytes_due.size() > start_depth) begin
			tail_byte = lcd_bytes_due.pop_back();
			tail_byte.last = 1'b1;
			lcd_bytes_due.push_back(tail_byte);
		end
	endfunction

	function automatic cmd_item_t random_cmd_item();
		cmd_item_t it;
		int pick;
		it.mode          = 3'($urandom_range(7));
		it.char_code     = 8'($urandom);
		it.target_line   = 1'($urandom);
		it.target_column = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 66) begin
			it.mode = MODE_CHAR;
			if ($urandom_range(99) < 10)
				it.char_code = CHAR_NEWLINE;
		end else if (pick < 82) begin
			it.mode = MODE_SETPOS;
			// Half of the moves land near the line end so that wraps come often.
			if ($urandom_range(1) == 0)
				it.target_column = 8'(COLUMNS * $urandom_range(15)
					+ $urandom_range(COLUMNS - 1, COLUMNS - 3));
		end else if (pick < 87) begin
			it.mode = MODE_CLEAR;
		end else if (pick < 92) begin
			it.mode = MODE_HOME;
		end else if (pick < 95) begin
			it.mode = MODE_INIT;
		end else begin
			it.mode = 3'($urandom_range(MODE_LAST_UNUSED, MODE_FIRST_UNUSED));
		end
		return it;
	endfunction

	task automatic queue_cmd(logic [2:0] mode, logic [7:0] ch, logic line, logic [7:0] col);
		cmd_backlog.push_back('{mode, ch, line, col});
	endtask

	// Command driver: a new item is presented only once the previous one is taken.
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t it;
		if (!arst_n) begin
			cmd.valid         <= 1'b0;
			cmd.mode          <= MODE_CHAR;
			cmd.char_code     <= 8'h00;
			cmd.target_line   <= 1'b0;
			cmd.target_column <= 8'h00;
		end else if (!cmd.valid || cmd.ready) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				it = cmd_backlog.pop_front();
				cmd.valid         <= 1'b1;
				cmd.mode          <= it.mode;
				cmd.char_code     <= it.char_code;
				cmd.target_line   <= it.target_line;
				cmd.target_column <= it.target_column;
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lcd.ready <= 1'b0;
		else
			lcd.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: predicts on every taken command and checks every taken byte.
	always @(posedge clk) begin
		lcd_byte_t want;
		if (arst_n) begin
			if (cmd.valid && cmd.ready) begin
				predict_lcd_bytes('{cmd.mode, cmd.char_code, cmd.target_line,
					cmd.target_column});
				items_taken++;
			end
			if (lcd.valid && lcd.ready) begin
				bytes_checked++;
				if (lcd_bytes_due.size() == 0) begin
					note_error("unexpected byte, expander_byte", -1, lcd.expander_byte);
				end else begin
					want = lcd_bytes_due.pop_front();
					if (lcd.expander_byte !== want.expander_byte)
						note_error("expander_byte", want.expander_byte, lcd.expander_byte);
					if (lcd.wait_after_us !== want.wait_after_us)
						note_error("wait_after_us", want.wait_after_us, lcd.wait_after_us);
					if (lcd.last !== want.last)
						note_error("last", want.last, lcd.last);
				end
			end
			if ((cmd.valid && cmd.ready) || (lcd.valid && lcd.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d bytes still due", $time,
					STALL_LIMIT, lcd_bytes_due.size());
				$display("tb_char_lcd_stream_sequencer_unit: errors");
				$finish;
			end
		end
	end

	initial begin
		int counted;
		cmd_item_t it;
		cur_line       = 1'b0;
		cur_col        = 6'd0;
		error_count    = 0;
		items_taken    = 0;
		bytes_checked  = 0;
		init_count     = 0;
		line_two_wraps = 0;
		clear_wraps    = 0;
		stall_cycles   = 0;
		send_idle_pct  = 15;
		recv_idle_pct  = 88;
		arst_n = 1'b0;

		// Directed opening: init, field extremes, both wrap kinds, newline on
		// each line, out-of-range columns and the ignored modes.
		queue_cmd(MODE_INIT, 8'h00, 1'b0, 8'h00);
		queue_cmd(MODE_CHAR, 8'h00, 1'b1, 8'hFF);
		queue_cmd(MODE_CHAR, 8'hFF, 1'b0, 8'h00);
		queue_cmd(MODE_CHAR, CHAR_NEWLINE, 1'b0, 8'h00);
		queue_cmd(MODE_CHAR, CHAR_NEWLINE, 1'b1, 8'hFF);
		queue_cmd(MODE_CLEAR, 8'hFF, 1'b1, 8'hFF);
		queue_cmd(MODE_HOME, 8'hA5, 1'b1, 8'h5A);
		queue_cmd(MODE_SETPOS, 8'h00, 1'b1, 8'hFF);
		queue_cmd(MODE_SETPOS, 8'h00, 1'b0, 8'(COLUMNS - 1));
		queue_cmd(MODE_CHAR, 8'h41, 1'b0, 8'h00);
		queue_cmd(MODE_CHAR, 8'h42, 1'b0, 8'h00);
		queue_cmd(MODE_SETPOS, 8'h00, 1'b1, 8'(2 * COLUMNS - 1));
		queue_cmd(MODE_CHAR, 8'h7E, 1'b0, 8'h00);
		queue_cmd(MODE_CHAR, 8'h80, 1'b0, 8'h00);
		queue_cmd(MODE_SETPOS, 8'h00, 1'b0, 8'(COLUMNS));
		queue_cmd(MODE_FIRST_UNUSED, 8'hFF, 1'b1, 8'hFF);
		queue_cmd(MODE_MID_UNUSED, 8'h00, 1'b0, 8'h00);
		queue_cmd(MODE_LAST_UNUSED, CHAR_NEWLINE, 1'b1, 8'h80);
		queue_cmd(MODE_SETPOS, 8'h00, 1'b1, 8'(COLUMNS - 1));
		queue_cmd(MODE_CHAR, 8'h20, 1'b0, 8'h00);
		queue_cmd(MODE_CHAR, CHAR_NEWLINE, 1'b0, 8'h00);
		queue_cmd(MODE_INIT, 8'hFF, 1'b1, 8'hFF);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			counted = 0;
			while (counted < RANDOM_PER_PHASE) begin
				it = random_cmd_item();
				cmd_backlog.push_back(it);
				if (it.mode <= MODE_INIT)
					counted++;
			end
			while (cmd_backlog.size() != 0 || cmd.valid)
				@(negedge clk);
		end

		while (lcd_bytes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d commands (%0d inits, %0d wraps to line two, %0d clearing wraps),",
			items_taken, init_count, line_two_wraps, clear_wraps);
		$display("checked %0d expander bytes under heavy, light and no idling on each side.",
			bytes_checked);
		if (error_count == 0)
			$display("tb_char_lcd_stream_sequencer_unit: clean");
		else
			$display("tb_char_lcd_stream_sequencer_unit: errors");
		$finish;
	end

endmodule

[char_lcd_stream_sequencer_unit.f]
+incdir+src
src/clss_pkg.sv
src/clss_cmd_if.sv
src/clss_byte_if.sv
src/clss_front.sv
src/clss_fifo.sv
src/clss_back.sv
src/char_lcd_stream_sequencer_unit.sv
verif/tb_char_lcd_stream_sequencer_unit.sv
